// File: src/ldsh_pkg.sv
// Shared types and constants for the length-prefixed deframer with sync hunt.
// No dependencies; imported by the input stage, the core, the result stage and the top level.
package ldsh_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam logic [LEN_W-1:0] SHORT_LIMIT      = 16'd4;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd2000;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  idx;
    logic [LEN_W-1:0]  len;
    logic              first;
    logic              last;
    logic              short_pkt;
  } res_t;

endpackage

// File: src/length_prefixed_deframer_sync_hunt.sv
// Top level of the length-prefixed deframer with sync marker hunt.
// Depends on ldsh_pkg, ldsh_in_stage, ldsh_core and ldsh_out_stage.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_stall, in_byte            | stream in
//   out     | out_valid, out_stall, out_byte, ...    | bytes out
//   cfg     | cfg_we, cfg_wdata (max_length)         | write only
//
// One byte per cycle sustained while out_stall is low; a payload byte passes
// through the input register and then the result register before it leaves.
// Length and marker bytes never wait on out_stall; payload bytes do.
// Reset is synchronous, active low; max_length returns to 2000.
module length_prefixed_deframer_sync_hunt
  import ldsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic [LEN_W-1:0]  out_byte_index,
  output logic [LEN_W-1:0]  out_packet_length,
  output logic              out_first_byte,
  output logic              out_last_byte,
  output logic              out_short_packet
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic              out_ready;
  res_t              res;

  ldsh_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  ldsh_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte),
    .out_ready (out_ready),
    .advance   (advance),
    .res       (res)
  );

  ldsh_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .out_ready         (out_ready),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_byte_index    (out_byte_index),
    .out_packet_length (out_packet_length),
    .out_first_byte    (out_first_byte),
    .out_last_byte     (out_last_byte),
    .out_short_packet  (out_short_packet)
  );

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_index < out_packet_length))
    else $error("byte index beyond packet length");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_byte == (out_byte_index == out_packet_length - 16'd1)))
    else $error("last mark not on final byte");

  a_short_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_short_packet == (out_packet_length <= SHORT_LIMIT)))
    else $error("short flag does not match length");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && res.vld && out_valid && out_stall))
    else $error("input stalled without a blocked payload byte");
`endif

endmodule

// File: src/ldsh_in_stage.sv
// Input register of the deframer: holds one accepted stream byte.
// Depends on ldsh_pkg for the byte width.
module ldsh_in_stage
  import ldsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              in_stall,
  input  logic              advance,
  output logic              s1_valid,
  output logic [BYTE_W-1:0] s1_byte
);

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

// File: src/ldsh_core.sv
// Deframer state: length capture, payload counting and sync marker matcher.
// Depends on ldsh_pkg for the result struct and constants.
module ldsh_core
  import ldsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              s1_valid,
  input  logic [BYTE_W-1:0] s1_byte,
  input  logic              out_ready,
  output logic              advance,
  output res_t              res
);

  localparam logic [1:0] PH_LEN_LO  = 2'd0;
  localparam logic [1:0] PH_LEN_HI  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_HUNT    = 2'd3;

  localparam logic [1:0] HUNT_NONE = 2'd0;
  localparam logic [1:0] HUNT_S    = 2'd1;
  localparam logic [1:0] HUNT_SR   = 2'd2;
  localparam logic [1:0] HUNT_SR0  = 2'd3;

  localparam logic [BYTE_W-1:0] CH_S    = 8'h73;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h72;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_ONE  = 8'h31;

  typedef struct packed {
    logic [1:0] st;
    logic       hit;
  } hunt_t;

  function automatic hunt_t hunt_step(input logic [1:0] st, input logic [BYTE_W-1:0] ch);
    hunt_t h;
    h.hit = 1'b0;
    case (st)
      HUNT_NONE: h.st = (ch == CH_S)    ? HUNT_S   : HUNT_NONE;
      HUNT_S:    h.st = (ch == CH_R)    ? HUNT_SR  : HUNT_NONE;
      HUNT_SR:   h.st = (ch == CH_ZERO) ? HUNT_SR0 : HUNT_NONE;
      default: begin
        h.st  = HUNT_NONE;
        h.hit = (ch == CH_ZERO) || (ch == CH_ONE);
      end
    endcase
    return h;
  endfunction

  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        hunt_r, hunt_nxt;
  logic [LEN_W-1:0]  max_len_r;
  logic [LEN_W-1:0]  len_in;
  logic              last;
  hunt_t             h_lo, h_hi, h_cur;

  assign len_in = {s1_byte, len_lo_r};
  assign last   = ({1'b0, cnt_r} + 17'd1) >= {1'b0, frame_len_r};
  assign h_lo   = hunt_step(HUNT_NONE, len_lo_r);
  assign h_hi   = hunt_step(h_lo.st, s1_byte);
  assign h_cur  = hunt_step(hunt_r, s1_byte);

  always_comb begin
    phase_nxt     = phase_r;
    len_lo_nxt    = len_lo_r;
    frame_len_nxt = frame_len_r;
    cnt_nxt       = cnt_r;
    hunt_nxt      = hunt_r;
    res.vld       = 1'b0;
    res.data      = s1_byte;
    res.idx       = cnt_r;
    res.len       = frame_len_r;
    res.first     = (cnt_r == '0);
    res.last      = last;
    res.short_pkt = (frame_len_r <= SHORT_LIMIT);
    case (phase_r)
      PH_LEN_LO: begin
        len_lo_nxt = s1_byte;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if ((len_in != '0) && (len_in <= max_len_r)) begin
          frame_len_nxt = len_in;
          cnt_nxt       = '0;
          phase_nxt     = PH_PAYLOAD;
        end else begin
          hunt_nxt  = h_hi.st;
          phase_nxt = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        res.vld = s1_valid;
        if (last) begin
          cnt_nxt   = '0;
          phase_nxt = PH_LEN_LO;
        end else begin
          cnt_nxt = cnt_r + 16'd1;
        end
      end
      default: begin
        hunt_nxt = h_cur.st;
        if (h_cur.hit) begin
          phase_nxt = PH_LEN_LO;
        end
      end
    endcase
  end

  // header and hunt bytes never wait on the result side
  assign advance = s1_valid && (!(phase_r == PH_PAYLOAD) || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN_LO;
      frame_len_r <= '0;
      cnt_r       <= '0;
      hunt_r      <= HUNT_NONE;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      cnt_r       <= cnt_nxt;
      hunt_r      <= hunt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      len_lo_r <= len_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

endmodule

// File: src/ldsh_out_stage.sv
// Result register of the deframer: holds one payload byte transaction.
// Depends on ldsh_pkg for the result struct.
module ldsh_out_stage
  import ldsh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  res_t              res,
  output logic              out_ready,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic [LEN_W-1:0]  out_byte_index,
  output logic [LEN_W-1:0]  out_packet_length,
  output logic              out_first_byte,
  output logic              out_last_byte,
  output logic              out_short_packet
);

  logic valid_r;
  res_t res_r;

  assign out_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res.vld) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = res_r.data;
  assign out_byte_index    = res_r.idx;
  assign out_packet_length = res_r.len;
  assign out_first_byte    = res_r.first;
  assign out_last_byte     = res_r.last;
  assign out_short_packet  = res_r.short_pkt;

endmodule
